// ===== rtl/mccd_pkg.sv =====
// ----------------------------------------------------------------------------
// mccd_pkg
// Shared widths, register indexes, reset values and types of the coin change
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package mccd_pkg;

	localparam int NSLOT      = 6;
	localparam int SLOT_W     = 3;
	localparam int COIN_W     = 10;
	localparam int CNT_W      = 10;
	localparam int AMT_W      = 10;
	localparam int MEM_W      = CNT_W + COIN_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [SLOT_W-1:0] MAX_COINS = 3'd6;

	localparam logic [CFG_IDX_W-1:0] REG_COIN_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COIN_0     = 3'd1;

	typedef logic [COIN_W-1:0] coin_t;
	typedef logic [NSLOT-1:0][COIN_W-1:0] coin_arr_t;
	typedef logic [NSLOT-1:0][CNT_W-1:0] cnt_arr_t;

	localparam logic [SLOT_W-1:0] COIN_COUNT_RST = 3'd4;
	localparam coin_arr_t COIN_RST = {10'd100, 10'd50, 10'd25, 10'd10, 10'd5, 10'd1};
	localparam coin_t COIN_ONE = 10'd1;

	typedef struct packed {
		logic [SLOT_W-1:0] coin_count;
		coin_arr_t         coin;
	} cfg_t;

	typedef struct packed {
		logic idle;
		logic done;
	} eng_stat_t;

	typedef struct packed {
		cnt_arr_t count;
		logic     too_large;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/mccd_if.sv =====
// ----------------------------------------------------------------------------
// mccd request and response channels
// Valid/ready channels carrying the change amount in and the coin counts out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mccd_req_if;
	import mccd_pkg::*;

	logic             valid;
	logic             ready;
	logic [AMT_W-1:0] change_value;

	modport source (output valid, output change_value, input ready);
	modport sink (input valid, input change_value, output ready);
endinterface

interface mccd_rsp_if;
	import mccd_pkg::*;

	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] count_0;
	logic [CNT_W-1:0] count_1;
	logic [CNT_W-1:0] count_2;
	logic [CNT_W-1:0] count_3;
	logic [CNT_W-1:0] count_4;
	logic [CNT_W-1:0] count_5;
	logic             too_large;

	modport source (output valid, output count_0, output count_1, output count_2,
		output count_3, output count_4, output count_5, output too_large, input ready);
	modport sink (input valid, input count_0, input count_1, input count_2,
		input count_3, input count_4, input count_5, input too_large, output ready);
endinterface

`default_nettype wire

// ===== rtl/mccd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mccd_cfg_regs
// Coin slot count and coin values, written through the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module mccd_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mccd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [mccd_pkg::CFG_DATA_W-1:0] cfg_data,
	output mccd_pkg::cfg_t                  cfg
);
	import mccd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coin_count <= COIN_COUNT_RST;
			cfg_q.coin       <= COIN_RST;
		end else if (cfg_we) begin
			if (cfg_idx == REG_COIN_COUNT) begin
				cfg_q.coin_count <= cfg_data[SLOT_W-1:0];
			end
			for (int j = 0; j < NSLOT; j++) begin
				if (cfg_idx == REG_COIN_0 + CFG_IDX_W'(j)) begin
					cfg_q.coin[j] <= COIN_W'(cfg_data);
				end
			end
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/mccd_table_mem.sv =====
// ----------------------------------------------------------------------------
// mccd_table_mem
// Single-port-write, single-port-read table memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mccd_table_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 20
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/mccd_engine.sv =====
// ----------------------------------------------------------------------------
// mccd_engine
// Fills the min-count / last-coin table one slot per cycle, then walks back
// from the amount one table read per cycle, counting coins per slot.
// ----------------------------------------------------------------------------
`default_nettype none

module mccd_engine #(
	parameter int MAX_VALUE = 1023
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mccd_pkg::cfg_t             cfg,
	input  logic                       start,
	input  logic [mccd_pkg::AMT_W-1:0] amount,
	input  logic                       take,
	output mccd_pkg::eng_stat_t        stat,
	output mccd_pkg::res_t             res
);
	import mccd_pkg::*;

	localparam int DEPTH = MAX_VALUE + 1;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_FILL   = 3'd1;
	localparam logic [2:0] S_WRITE  = 3'd2;
	localparam logic [2:0] S_WSTART = 3'd3;
	localparam logic [2:0] S_WALK   = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0]        state_q;
	logic [AMT_W-1:0]  amt_q;
	logic [AMT_W-1:0]  i_q;
	logic [AMT_W-1:0]  rem_q;
	logic [AMT_W-1:0]  nrem;
	logic [CNT_W-1:0]  best_q;
	logic [CNT_W-1:0]  best_nx;
	logic [CNT_W-1:0]  cand;
	logic [CNT_W-1:0]  rd_cnt;
	coin_t             used_q;
	coin_t             used_nx;
	coin_t             c_fill;
	coin_t             c_s1;
	coin_t             rd_coin;
	logic [SLOT_W-1:0] k_q;
	logic [SLOT_W-1:0] n_act;
	logic [SLOT_W-1:0] n_last;
	logic              fit;
	logic              big;
	logic              v_s1;
	logic              z_s1;
	cnt_arr_t          cnt_q;
	logic              tl_q;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic [MEM_W-1:0]  wdata;
	logic [MEM_W-1:0]  rdata;

	mccd_table_mem #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (MEM_W)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign n_act  = (cfg.coin_count > MAX_COINS) ? MAX_COINS : cfg.coin_count;
	assign n_last = n_act - SLOT_W'(1);
	assign big    = 32'(amount) > 32'(MAX_VALUE);

	assign c_fill = cfg.coin[k_q];
	assign fit    = (c_fill != '0) && (c_fill <= i_q);

	assign {rd_cnt, rd_coin} = rdata;
	assign nrem = rem_q - rd_coin;

	// entry zero is never stored: a coin equal to the amount gives count one
	always_comb begin
		cand    = z_s1 ? CNT_W'(1) : rd_cnt + CNT_W'(1);
		best_nx = best_q;
		used_nx = used_q;
		if (v_s1 && (cand < best_q)) begin
			best_nx = cand;
			used_nx = c_s1;
		end
	end

	always_comb begin
		unique case (state_q)
			S_FILL:   raddr = AW'(i_q - c_fill);
			S_WSTART: raddr = AW'(amt_q);
			S_WALK:   raddr = AW'(nrem);
			default:  raddr = '0;
		endcase
	end

	assign we    = (state_q == S_WRITE);
	assign waddr = AW'(i_q);
	assign wdata = {best_nx, used_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_FILL) && fit;
		end
	end

	always_ff @(posedge clk) begin
		z_s1 <= (c_fill == i_q);
		c_s1 <= c_fill;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			amt_q   <= '0;
			i_q     <= '0;
			rem_q   <= '0;
			best_q  <= '0;
			used_q  <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
			tl_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						amt_q  <= amount;
						cnt_q  <= '0;
						tl_q   <= big;
						i_q    <= AMT_W'(1);
						best_q <= CNT_W'(1);
						used_q <= COIN_ONE;
						k_q    <= n_last;
						if (big || (amount == '0)) begin
							state_q <= S_DONE;
						end else if (n_act == '0) begin
							state_q <= S_WRITE;
						end else begin
							state_q <= S_FILL;
						end
					end
				end
				S_FILL: begin
					best_q <= best_nx;
					used_q <= used_nx;
					k_q    <= k_q - SLOT_W'(1);
					if (k_q == '0) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (i_q == amt_q) begin
						state_q <= S_WSTART;
					end else begin
						i_q    <= i_q + AMT_W'(1);
						best_q <= CNT_W'(i_q + AMT_W'(1));
						used_q <= COIN_ONE;
						k_q    <= n_last;
						state_q <= (n_act == '0) ? S_WRITE : S_FILL;
					end
				end
				S_WSTART: begin
					rem_q   <= amt_q;
					state_q <= S_WALK;
				end
				S_WALK: begin
					for (int j = 0; j < NSLOT; j++) begin
						if ((SLOT_W'(j) < n_act) && (cfg.coin[j] == rd_coin)) begin
							cnt_q[j] <= cnt_q[j] + CNT_W'(1);
						end
					end
					rem_q <= nrem;
					if (nrem == '0) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.idle     = (state_q == S_IDLE);
	assign stat.done     = (state_q == S_DONE);
	assign res.count     = cnt_q;
	assign res.too_large = tl_q;

endmodule

`default_nettype wire

// ===== rtl/min_coin_change_dp.sv =====
// ----------------------------------------------------------------------------
// min_coin_change_dp
// Minimum-coin change maker: per coin slot, the coins of a fewest-coin change.
// ----------------------------------------------------------------------------
// One item is worked on at a time. For an amount A the table fill steps
// through the amounts from one up to A, one active slot per cycle through
// the table memory's single read port plus a write step per amount, and the
// walk back reads the table once per coin in the result. An amount of zero
// or above MAX_VALUE skips the fill and the walk. The result waits in an
// output register, so the next item is taken while it is held.
// The table needs no clearing pass after reset.
`default_nettype none

module min_coin_change_dp #(
	parameter int MAX_VALUE = 1023
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mccd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [mccd_pkg::CFG_DATA_W-1:0] cfg_data,
	mccd_req_if.sink                        in_ch,
	mccd_rsp_if.source                      out_ch
);
	import mccd_pkg::*;

	cfg_t      cfg;
	eng_stat_t stat;
	res_t      res;
	res_t      out_q;
	logic      out_valid_q;
	logic      start;
	logic      take;

	mccd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	mccd_engine #(
		.MAX_VALUE (MAX_VALUE)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.start  (start),
		.amount (in_ch.change_value),
		.take   (take),
		.stat   (stat),
		.res    (res)
	);

	assign in_ch.ready = stat.idle;
	assign start       = in_ch.valid & stat.idle;
	assign take        = stat.done & (~out_valid_q | out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.count_0   = out_q.count[0];
	assign out_ch.count_1   = out_q.count[1];
	assign out_ch.count_2   = out_q.count[2];
	assign out_ch.count_3   = out_q.count[3];
	assign out_ch.count_4   = out_q.count[4];
	assign out_ch.count_5   = out_q.count[5];
	assign out_ch.too_large = out_q.too_large;

endmodule

`default_nettype wire

// ===== rtl/mccd_checker.sv =====
// ----------------------------------------------------------------------------
// mccd_checker
// Port-level checks of the coin change block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mccd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [mccd_pkg::CNT_W-1:0]  count_0,
	input logic [mccd_pkg::CNT_W-1:0]  count_1,
	input logic [mccd_pkg::CNT_W-1:0]  count_2,
	input logic [mccd_pkg::CNT_W-1:0]  count_3,
	input logic [mccd_pkg::CNT_W-1:0]  count_4,
	input logic [mccd_pkg::CNT_W-1:0]  count_5,
	input logic                        too_large
);

	// no item shows up on the output while in reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an accept");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(count_0) && $stable(count_1)
		&& $stable(count_2) && $stable(count_3) && $stable(count_4)
		&& $stable(count_5) && $stable(too_large))
		else $error("stalled result changed");

	// an out-of-range amount reports no coins
	a_too_large_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_large |-> count_0 == '0 && count_1 == '0 && count_2 == '0
		&& count_3 == '0 && count_4 == '0 && count_5 == '0)
		else $error("coins reported with too_large");

endmodule

bind min_coin_change_dp mccd_checker u_mccd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.count_0   (out_ch.count_0),
	.count_1   (out_ch.count_1),
	.count_2   (out_ch.count_2),
	.count_3   (out_ch.count_3),
	.count_4   (out_ch.count_4),
	.count_5   (out_ch.count_5),
	.too_large (out_ch.too_large)
);

`default_nettype wire

// ===== sim/coin_count_checker.sv =====
// ----------------------------------------------------------------------------
// coin_count_checker
// Watches the coin setting writes and both channels of the change maker,
// works out the fewest-coin split of every accepted amount and compares each
// result item field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module coin_count_checker
	import mccd_pkg::*;
#(
	parameter int MAX_AMOUNT = 1023
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	mccd_req_if                   req,
	mccd_rsp_if                   rsp,
	output int                    errors,
	output int                    pending,
	output int                    checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [AMT_W-1:0] amount;
		res_t             split;
	} split_entry_t;

	cfg_t         coins_now;
	split_entry_t expected_splits[$];
	int           fail_total;
	int           check_total;

	initial begin
		fail_total = 0;
		check_total = 0;
		errors = 0;
		pending = 0;
		checked = 0;
	end

	function automatic res_t fewest_coins(input logic [AMT_W-1:0] amount, input cfg_t s);
		logic [CNT_W-1:0] best_tbl [0:MAX_AMOUNT];
		coin_t            used_tbl [0:MAX_AMOUNT];
		res_t             r;
		int               n;
		int               best;
		int               cand;
		int               rem;
		int               tally [NSLOT];
		coin_t            used;
		coin_t            c;
		r = '0;
		if (amount > MAX_AMOUNT) begin
			r.too_large = 1'b1;
			return r;
		end
		n = (s.coin_count > MAX_COINS) ? MAX_COINS : s.coin_count;
		best_tbl[0] = '0;
		used_tbl[0] = '0;
		for (int i = 1; i <= amount; i++) begin
			best = i;
			used = COIN_ONE;
			for (int k = n - 1; k >= 0; k--) begin
				c = s.coin[k];
				if (c != 0 && c <= i) begin
					cand = best_tbl[i - c] + 1;
					if (cand < best) begin
						best = cand;
						used = c;
					end
				end
			end
			best_tbl[i] = best[CNT_W-1:0];
			used_tbl[i] = used;
		end
		foreach (tally[j]) tally[j] = 0;
		rem = amount;
		while (rem > 0) begin
			c = used_tbl[rem];
			for (int j = 0; j < n; j++) begin
				if (s.coin[j] == c) tally[j]++;
			end
			rem -= c;
		end
		for (int j = 0; j < NSLOT; j++) r.count[j] = tally[j][CNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t         got;
		split_entry_t want;
		if (!arst_n) begin
			coins_now.coin_count = COIN_COUNT_RST;
			coins_now.coin = COIN_RST;
			expected_splits.delete();
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.count = {rsp.count_5, rsp.count_4, rsp.count_3,
					rsp.count_2, rsp.count_1, rsp.count_0};
				got.too_large = rsp.too_large;
				if (expected_splits.size() == 0) begin
					$display("%0t ns: unexpected item, expected none, got counts %p too_large %0b",
						$time, got.count, got.too_large);
					fail_total++;
				end else begin
					want = expected_splits.pop_front();
					check_total++;
					for (int j = 0; j < NSLOT; j++) begin
						if (got.count[j] !== want.split.count[j]) begin
							$display("%0t ns: amount %0d count_%0d expected %0d, got %0d",
								$time, want.amount, j, want.split.count[j], got.count[j]);
							fail_total++;
						end
					end
					if (got.too_large !== want.split.too_large) begin
						$display("%0t ns: amount %0d too_large expected %0b, got %0b",
							$time, want.amount, want.split.too_large, got.too_large);
						fail_total++;
					end
				end
			end
			if (req.valid && req.ready) begin
				want.amount = req.change_value;
				want.split = fewest_coins(req.change_value, coins_now);
				expected_splits.push_back(want);
			end
			if (cfg_we) begin
				if (cfg_idx == REG_COIN_COUNT) begin
					coins_now.coin_count = cfg_data[SLOT_W-1:0];
				end else if (cfg_idx >= REG_COIN_0 && cfg_idx < REG_COIN_0 + NSLOT) begin
					coins_now.coin[cfg_idx - REG_COIN_0] = cfg_data[COIN_W-1:0];
				end
			end
			pending <= expected_splits.size();
		end
		errors <= fail_total;
		checked <= check_total;
	end

endmodule

// ===== sim/tb_min_coin_change_dp.sv =====
// ----------------------------------------------------------------------------
// tb_min_coin_change_dp
// Drives change amounts and coin settings into the change maker under
// shifting sender and receiver stall patterns; a side checker predicts and
// compares every result item and reports failures back here for the verdict.
// ----------------------------------------------------------------------------
module tb_min_coin_change_dp;
	timeunit 1ns;
	timeprecision 1ps;

	import mccd_pkg::*;

	localparam int                   MAX_AMOUNT = 1023;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd7;
	localparam int                   LONG_HOLD  = 1500;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	bit long_hold_req = 1'b0;
	int errors;
	int pending;
	int checked;
	int sent = 0;
	int settings = 0;

	mccd_req_if req_ch ();
	mccd_rsp_if rsp_ch ();

	min_coin_change_dp #(
		.MAX_VALUE(MAX_AMOUNT)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.in_ch   (req_ch),
		.out_ch  (rsp_ch)
	);

	coin_count_checker #(
		.MAX_AMOUNT(MAX_AMOUNT)
	) u_coin_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.errors  (errors),
		.pending (pending),
		.checked (checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// receiver side, with an optional long hold-off
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				hold_left = LONG_HOLD;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	task automatic load_setting(input cfg_t s);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= REG_COIN_COUNT;
		cfg_data <= CFG_DATA_W'(s.coin_count);
		for (int k = 0; k < NSLOT; k++) begin
			@(negedge clk);
			cfg_idx <= CFG_IDX_W'(REG_COIN_0 + k);
			cfg_data <= s.coin[k];
		end
		@(negedge clk);
		cfg_idx <= REG_SPARE;
		cfg_data <= CFG_DATA_W'($urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic send_amount(input logic [AMT_W-1:0] amount);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.change_value <= amount;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [AMT_W-1:0] pick_amount();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) return AMT_W'($urandom_range(900, 1023));
		if (r < 20) return AMT_W'($urandom_range(64, 511));
		return AMT_W'($urandom_range(0, 63));
	endfunction

	function automatic cfg_t random_setting();
		cfg_t s;
		int   r;
		r = $urandom_range(0, 99);
		if (r < 6) s.coin_count = '0;
		else if (r < 12) s.coin_count = 3'd7;
		else s.coin_count = SLOT_W'($urandom_range(1, 6));
		for (int k = 0; k < NSLOT; k++) begin
			r = $urandom_range(0, 99);
			if (r < 5) s.coin[k] = '0;
			else if (r < 30) s.coin[k] = COIN_W'($urandom_range(1, 1023));
			else s.coin[k] = COIN_W'($urandom_range(1, 40));
		end
		if ($urandom_range(0, 1)) s.coin[0] = COIN_ONE;
		return s;
	endfunction

	initial begin
		int   stock_amts[]  = '{0, 1, 4, 5, 6, 30, 99, 1023, 682, 341};
		int   odd_amts[]    = '{1, 2, 14, 1023, 21, 1000};
		cfg_t s;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.change_value = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// coins as they come out of reset
		foreach (stock_amts[i]) send_amount(AMT_W'(stock_amts[i]));
		drain();

		// duplicate values, a zero coin and no coin of one
		s.coin_count = 3'd6;
		s.coin = {10'd11, 10'd1023, 10'd0, 10'd7, 10'd7, 10'd3};
		load_setting(s);
		foreach (odd_amts[i]) send_amount(AMT_W'(odd_amts[i]));
		drain();

		// every slot worth one, slot count above the maximum
		s.coin_count = 3'd7;
		s.coin = {NSLOT{COIN_ONE}};
		load_setting(s);
		send_amount(10'd1023);
		send_amount(10'd3);
		drain();

		// no active slot
		s.coin_count = 3'd0;
		s.coin = COIN_RST;
		load_setting(s);
		send_amount(10'd500);
		send_amount(10'd7);
		drain();

		// one slot holding the largest coin
		s.coin_count = 3'd1;
		s.coin = {NSLOT{10'd1023}};
		load_setting(s);
		send_amount(10'd1022);
		send_amount(10'd1023);
		drain();

		for (int g = 0; g < 3; g++) begin
			case (g)
				0: begin
					send_gap_pct = 6;
					recv_stall_pct = 82;
				end
				1: begin
					send_gap_pct = 82;
					recv_stall_pct = 6;
				end
				default: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int p = 0; p < 2; p++) begin
				if (g == 2 && p == 0) long_hold_req = 1'b1;
				load_setting(random_setting());
				repeat (13) begin
					if (g == 2 && p == 0) send_amount(AMT_W'($urandom_range(0, 63)));
					else send_amount(pick_amount());
				end
				drain();
			end
		end

		repeat (50) @(posedge clk);
		$display("run covered %0d amounts under %0d coin settings, %0d results checked",
			sent, settings, checked);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
